// ===== rtl/assert_macros.svh =====
// assertion macros used by mhq_back
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is disabled while reset is high
`define MHQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MHQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mhq_pkg.sv =====
// shared types and constants of the min-heap priority queue
// no dependencies
package mhq_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam logic [6:0] CAPACITY_RESET = 7'd64;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_EXTRACT = 1'b1;

   typedef struct packed {
      logic               is_extract;
      logic signed [31:0] key;
   } op_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] key;
      logic [6:0]         count;
   } res_type;

endpackage

// ===== rtl/mhq_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module mhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mhq_fifo.sv =====
// two-entry register queue used between the block's parts
// no dependencies
module mhq_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== rtl/mhq_front.sv =====
// front part: accepts request beats, decodes the command, queues operations
// depends on mhq_pkg and mhq_fifo
module mhq_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                req_cmd,
   input  logic signed [31:0]  req_key_in,
   output logic                op_valid,
   output mhq_pkg::op_type     op,
   input  logic                op_take
);

   mhq_pkg::op_type op_wr;
   logic [$bits(mhq_pkg::op_type)-1:0] op_rd;
   logic op_empty;

   always_comb begin
      op_wr.is_extract = (req_cmd == mhq_pkg::CMD_EXTRACT);
      // key is ignored on extract, keep it zero
      op_wr.key = op_wr.is_extract ? 32'sd0 : req_key_in;
   end

   mhq_fifo #(.WIDTH($bits(mhq_pkg::op_type))) u_op_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (op_wr),
      .full  (full),
      .pop   (op_take),
      .dout  (op_rd),
      .empty (op_empty)
   );

   assign op_valid = !op_empty;
   assign op       = mhq_pkg::op_type'(op_rd);

endmodule

// ===== rtl/mhq_back.sv =====
// back part: heap sequencer that runs sift-up and sift-down over the store
// depends on mhq_pkg, mhq_ram and assert_macros.svh
`include "assert_macros.svh"
module mhq_back #(
   parameter int MAX_ENTRIES = mhq_pkg::MAX_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [6:0]         capacity,
   input  logic               op_valid,
   input  mhq_pkg::op_type    op,
   output logic               op_take,
   input  logic               res_full,
   output logic               res_push,
   output mhq_pkg::res_type   res
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int LW = (CW > 7) ? CW : 7;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_UP_CHK  = 4'd1;
   localparam logic [3:0] S_UP_CMP  = 4'd2;
   localparam logic [3:0] S_EX_ROOT = 4'd3;
   localparam logic [3:0] S_EX_LAST = 4'd4;
   localparam logic [3:0] S_DN_CHK  = 4'd5;
   localparam logic [3:0] S_DN_L    = 4'd6;
   localparam logic [3:0] S_DN_R    = 4'd7;
   localparam logic [3:0] S_DN_MOVE = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      best_ff, best_in;
   logic signed [31:0] cur_ff, cur_in;
   logic signed [31:0] bv_ff, bv_in;
   logic signed [31:0] out_key_ff, out_key_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        rd_raw;
   logic signed [31:0] rd_key;

   logic [LW-1:0]      lim;
   logic               at_limit;
   logic [AW-1:0]      parent;
   logic [AW+1:0]      left_idx, right_idx, count_w;

   mhq_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_key = $signed(rd_raw);

   always_comb begin
      // effective limit saturates at the store depth
      lim = (LW'(capacity) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(capacity);
      at_limit  = (LW'(count_ff) >= lim);
      parent    = (pos_ff - AW'(1)) >> 1;
      left_idx  = {1'b0, pos_ff, 1'b1};
      right_idx = left_idx + (AW+2)'(1);
      count_w   = (AW+2)'(count_ff);
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      best_in    = best_ff;
      cur_in     = cur_ff;
      bv_in      = bv_ff;
      out_key_in = out_key_ff;
      op_take    = 1'b0;
      res_push   = 1'b0;
      res.status = mhq_pkg::ST_DONE;
      res.key    = out_key_ff;
      res.count  = 7'(count_ff);
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = cur_ff;
      rd_addr    = '0;
      case (state_ff)
         S_IDLE: begin
            // result queue has room, so the end-of-operation push never stalls
            if (op_valid && !res_full) begin
               op_take    = 1'b1;
               out_key_in = 32'sd0;
               if (!op.is_extract) begin
                  if (at_limit) begin
                     res_push   = 1'b1;
                     res.status = mhq_pkg::ST_FULL;
                     res.key    = 32'sd0;
                  end else begin
                     cur_in   = op.key;
                     pos_in   = AW'(count_ff);
                     count_in = count_ff + CW'(1);
                     state_in = S_UP_CHK;
                  end
               end else if (count_ff == '0) begin
                  res_push   = 1'b1;
                  res.status = mhq_pkg::ST_EMPTY;
                  res.key    = 32'sd0;
               end else begin
                  rd_addr  = '0;
                  count_in = count_ff - CW'(1);
                  state_in = S_EX_ROOT;
               end
            end
         end
         S_UP_CHK: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               res_push = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr  = parent;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (cur_ff < rd_key) begin
               // parent moves down into the hole
               wr_data  = rd_raw;
               pos_in   = parent;
               state_in = S_UP_CHK;
            end else begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EX_ROOT: begin
            out_key_in = rd_key;
            if (count_ff == '0) begin
               res_push = 1'b1;
               res.key  = rd_key;
               state_in = S_IDLE;
            end else begin
               rd_addr  = AW'(count_ff);
               state_in = S_EX_LAST;
            end
         end
         S_EX_LAST: begin
            cur_in   = rd_key;
            pos_in   = '0;
            state_in = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (left_idx >= count_w) begin
               wr_en    = 1'b1;
               res_push = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr  = AW'(left_idx);
               state_in = S_DN_L;
            end
         end
         S_DN_L: begin
            if (rd_key < cur_ff) begin
               best_in = AW'(left_idx);
               bv_in   = rd_key;
            end else begin
               best_in = pos_ff;
               bv_in   = cur_ff;
            end
            if (right_idx < count_w) begin
               rd_addr  = AW'(right_idx);
               state_in = S_DN_R;
            end else begin
               state_in = S_DN_MOVE;
            end
         end
         S_DN_R: begin
            if (rd_key < bv_ff) begin
               best_in = AW'(right_idx);
               bv_in   = rd_key;
            end
            state_in = S_DN_MOVE;
         end
         S_DN_MOVE: begin
            wr_en = 1'b1;
            if (best_ff == pos_ff) begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end else begin
               // smaller child moves up into the hole
               wr_data  = bv_ff;
               pos_in   = best_ff;
               state_in = S_DN_CHK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      best_ff    <= best_in;
      cur_ff     <= cur_in;
      bv_ff      <= bv_in;
      out_key_ff <= out_key_in;
   end

   `MHQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(MAX_ENTRIES), "count above depth")
   `MHQ_ASSERT(a_push_room, clock, reset, res_push |-> !res_full, "result push into full queue")
   `MHQ_ASSERT(a_take_idle, clock, reset, op_take |=> $past(state_ff) == S_IDLE, "take while busy")
   `MHQ_ASSERT(a_insert_grows, clock, reset,
      (op_take && !op.is_extract && !at_limit) |=> count_ff == $past(count_ff) + CW'(1),
      "insert did not grow count")

endmodule

// ===== rtl/min_heap_priority_queue_unit.sv =====
// top level of the min-heap priority queue
// depends on mhq_pkg, mhq_front, mhq_back and mhq_fifo
//
// request channel: a beat is taken when push is high and full is low; req_cmd
// selects insert (key in req_key_in) or extract of the minimum
// response channel: the oldest result sits on rsp_* while empty is low and
// leaves on a cycle with pop high; every request gives exactly one result
// config channel: csr_capacity is written when csr_valid and csr_ready are
// both high; csr_ready is always high, write only while the block is idle
// heap engine: a rejected insert or an empty extract is answered from idle; an
// insert climbs with one registered ram read of the parent and a compare per
// level; an extract reads the root and, unless it was the last key, the last
// key, then descends with one registered ram read and compare per child; each
// request also passes through the request queue; one operation runs at a time
// two-entry queues sit before and after the engine, so requests are taken
// while a result waits and a stalled receiver only blocks once both fill
// reset: heap empty, capacity 64, both queues empty; store content is left
module min_heap_priority_queue_unit #(
   parameter int MAX_ENTRIES = mhq_pkg::MAX_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_cmd,
   input  logic signed [31:0] req_key_in,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_key_out,
   output logic [6:0]         rsp_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_capacity
);

   // capacity register
   logic [6:0] capacity_ff, capacity_in;

   // front to back operation link
   logic            op_valid;
   mhq_pkg::op_type op;
   logic            op_take;

   // back to response queue link
   logic             res_full;
   logic             res_push;
   mhq_pkg::res_type res;
   logic [$bits(mhq_pkg::res_type)-1:0] res_rd;
   mhq_pkg::res_type rsp;

   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_capacity : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= mhq_pkg::CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   mhq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_cmd    (req_cmd),
      .req_key_in (req_key_in),
      .op_valid   (op_valid),
      .op         (op),
      .op_take    (op_take)
   );

   mhq_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .capacity (capacity_ff),
      .op_valid (op_valid),
      .op       (op),
      .op_take  (op_take),
      .res_full (res_full),
      .res_push (res_push),
      .res      (res)
   );

   // response queue decouples a stalled receiver from the engine
   mhq_fifo #(.WIDTH($bits(mhq_pkg::res_type))) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res),
      .full  (res_full),
      .pop   (pop),
      .dout  (res_rd),
      .empty (empty)
   );

   assign rsp         = mhq_pkg::res_type'(res_rd);
   assign rsp_status  = rsp.status;
   assign rsp_key_out = rsp.key;
   assign rsp_count   = rsp.count;

endmodule
